>>> src/point_to_screen_projection_core_macros.svh
// assertion macros for the point-to-screen projection core
// used by the top level only; expects clk and rst_n in scope
`ifndef POINT_TO_SCREEN_PROJECTION_CORE_MACROS_SVH
`define POINT_TO_SCREEN_PROJECTION_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PTSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PTSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PTSP_ASSERT(lbl, prop, msg)
`define PTSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/ptsp_pkg.sv
// shared types, constants and saturation helper for the projection core
// no dependencies
package ptsp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int QW         = 32;
  localparam int PROD_W     = 2 * QW;
  localparam int TERM_W     = PROD_W - FRAC_BITS;
  localparam int SUM_W      = TERM_W + 2;
  localparam int IDX_W      = 5;
  localparam int MV_N       = 16;
  localparam int DIM_W      = 13;
  localparam int OFS_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DIV_STEPS  = QW - 1;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 96;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VP_X      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VP_Y      = 2'd3;

  localparam logic [DIM_W-1:0] VP_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] VP_HEIGHT_RST = 13'd480;
  localparam logic [OFS_W-1:0] VP_X_RST      = 12'd0;
  localparam logic [OFS_W-1:0] VP_Y_RST      = 12'd0;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [QW:0] ONE_X = (QW+1)'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    KIND_LOAD_MV,
    KIND_LOAD_PJ,
    KIND_PROJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [IDX_W-2:0]     idx;
    q_t                   value;
    q_t                   pos_x;
    q_t                   pos_y;
    q_t                   pos_z;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [OFS_W-1:0] x;
    logic [OFS_W-1:0] y;
  } vp_cfg_t;

  function automatic q_t sat_sum(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(Q_MAX);
    lo = SUM_W'(Q_MIN);
    if (v > hi) sat_sum = Q_MAX;
    else if (v < lo) sat_sum = Q_MIN;
    else sat_sum = v[QW-1:0];
  endfunction

endpackage

>>> src/ptsp_front.sv
// front end: takes input beats, decodes the operation and feeds the queue
// depends on ptsp_pkg
module ptsp_front import ptsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  output logic                 push,
  output cmd_t                 push_cmd,
  input  q_status_t            q_status
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;

  assign push      = valid_r && !q_status.full;
  assign in_tready = !valid_r || !q_status.full;
  assign push_cmd  = cmd_r;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (push) valid_nxt = 1'b0;
    if (in_tvalid && in_tready) begin
      valid_nxt     = 1'b1;
      cmd_nxt.idx   = in_tdata[IDX_W-2:0];
      cmd_nxt.value = in_tdata[IDX_W +: QW];
      cmd_nxt.pos_x = in_tdata[IDX_W+QW +: QW];
      cmd_nxt.pos_y = in_tdata[IDX_W+2*QW +: QW];
      cmd_nxt.pos_z = in_tdata[IDX_W+3*QW +: QW];
      // top index bit picks the projection matrix
      priority if (in_tuser == OP_PROJECT) cmd_nxt.kind = KIND_PROJECT;
      else if (in_tdata[IDX_W-1]) cmd_nxt.kind = KIND_LOAD_PJ;
      else cmd_nxt.kind = KIND_LOAD_MV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

>>> src/ptsp_queue.sv
// short command queue between the front end and the arithmetic back end
// depends on ptsp_pkg
module ptsp_queue import ptsp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t           mem_r [DEPTH];
  logic [PW-1:0]  wr_r, rd_r;
  logic [CW-1:0]  cnt_r;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status.full  = (cnt_r == CW'(DEPTH));
  assign status.empty = (cnt_r == '0);
  assign head         = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= next_ptr(wr_r);
      if (pop) rd_r <= next_ptr(rd_r);
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> src/ptsp_divider.sv
// pipelined restoring divider: (num << FRAC_BITS) / den, truncated, saturated
// one quotient bit per stage; depends on ptsp_pkg
module ptsp_divider import ptsp_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  q_t            num,
  input  logic [QW-1:0] den_mag,
  input  logic          den_neg,
  output q_t            quo
);

  logic [QW-1:0]           mag;
  logic [QW+FRAC_BITS-1:0] dividend;
  logic [QW-1:0]           rem0;

  logic [QW-1:0] rem_r  [DIV_STEPS];
  logic [QW-2:0] bits_r [DIV_STEPS];
  logic [QW-1:0] den_r  [DIV_STEPS];
  logic [QW-2:0] quo_r  [DIV_STEPS+1];
  logic          ovf_r  [DIV_STEPS+1];
  logic          neg_r  [DIV_STEPS+1];
  q_t            quo_out_r;
  q_t            quo_pos;

  assign mag      = num[QW-1] ? QW'(-num) : QW'(num);
  assign dividend = {mag, {FRAC_BITS{1'b0}}};
  assign rem0     = QW'(dividend[QW+FRAC_BITS-1:QW-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem0;
      bits_r[0] <= dividend[QW-2:0];
      den_r[0]  <= den_mag;
      quo_r[0]  <= '0;
      // quotient of 2^31 or more saturates
      ovf_r[0]  <= (rem0 >= den_mag);
      neg_r[0]  <= num[QW-1] ^ den_neg;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [QW-1:0] trial;
    logic          ge;
    assign trial = {rem_r[k][QW-2:0], bits_r[k][QW-2]};
    assign ge    = (trial >= den_r[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k+1] <= {quo_r[k][QW-3:0], ge};
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
    if (k < DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1]  <= ge ? trial - den_r[k] : trial;
          bits_r[k+1] <= {bits_r[k][QW-3:0], 1'b0};
          den_r[k+1]  <= den_r[k];
        end
      end
    end
  end

  assign quo_pos = {1'b0, quo_r[DIV_STEPS]};

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (ovf_r[DIV_STEPS]) quo_out_r <= neg_r[DIV_STEPS] ? Q_MIN : Q_MAX;
      else if (neg_r[DIV_STEPS]) quo_out_r <= -quo_pos;
      else quo_out_r <= quo_pos;
    end
  end

  assign quo = quo_out_r;

endmodule

>>> src/ptsp_back.sv
// back end: matrix products, perspective divide, viewport map, result register
// depends on ptsp_pkg and ptsp_divider
module ptsp_back import ptsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  head,
  input  q_status_t             q_status,
  output logic                  pop,
  input  vp_cfg_t               cfg,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int VMUL_W = QW + DIM_W + 2;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [VMUL_W-1:0] vmul_t;

  logic adv;

  q_t mv_r [MV_N];
  q_t pj_r [MV_N];
  q_t pos  [3];

  logic             a_valid_r;
  cmd_kind_t        a_kind_r;
  logic [IDX_W-2:0] a_idx_r;
  q_t               a_val_r;
  prod_t            a_prod_r [4][3];
  q_t               a_trans_r [4];

  logic             b_valid_r;
  cmd_kind_t        b_kind_r;
  logic [IDX_W-2:0] b_idx_r;
  q_t               b_val_r;
  q_t               b_eye_r [4];

  q_t            eye_z;
  logic          c_valid_r, c_zero_r, c_den_neg_r;
  logic [QW-1:0] c_den_mag_r;
  prod_t         c_prod_r [3][4];

  logic          d_valid_r, d_zero_r, d_den_neg_r;
  logic [QW-1:0] d_den_mag_r;
  q_t            d_clip_r [3];

  q_t                  ndc [3];
  logic signed [QW:0]  ndc1 [3];
  logic [DIV_LAT-1:0]  sv_valid_r, sv_zero_r;

  logic               f_valid_r, f_zero_r;
  vmul_t              f_x_r, f_y_r;
  logic signed [QW:0] f_z_r;

  logic g_valid_r, g_zero_r;
  q_t   g_sx_r, g_sy_r, g_sd_r;

  logic out_valid_r, out_ok_r;
  q_t   out_x_r, out_y_r, out_d_r;

  sum_t  x_off, y_off, h_off;
  vmul_t w_mul, h_mul;

  // whole pipeline moves together whenever the result register can take a beat
  assign adv = !out_valid_r || out_tready;
  assign pop = adv && !q_status.empty;

  assign pos[0] = head.pos_x;
  assign pos[1] = head.pos_y;
  assign pos[2] = head.pos_z;

  // modelview writes land as the load leaves the queue, projection writes as it
  // leaves stage b, so every point sees exactly the loads ahead of it
  always_ff @(posedge clk) begin
    if (pop && head.kind == KIND_LOAD_MV) mv_r[head.idx] <= head.value;
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid_r && b_kind_r == KIND_LOAD_PJ) pj_r[b_idx_r] <= b_val_r;
  end

  // eye = MV * (x, y, z, 1)
  for (genvar r = 0; r < 4; r++) begin : g_mv
    sum_t acc;
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (adv) a_prod_r[r][c] <= PROD_W'(mv_r[c*4+r]) * PROD_W'(pos[c]);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) a_trans_r[r] <= mv_r[12+r];
    end
    assign acc = SUM_W'(a_prod_r[r][0] >>> FRAC_BITS) + SUM_W'(a_prod_r[r][1] >>> FRAC_BITS)
               + SUM_W'(a_prod_r[r][2] >>> FRAC_BITS) + SUM_W'(a_trans_r[r]);
    always_ff @(posedge clk) begin
      if (adv) b_eye_r[r] <= sat_sum(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind_r <= head.kind;
      a_idx_r  <= head.idx;
      a_val_r  <= head.value;
      b_kind_r <= a_kind_r;
      b_idx_r  <= a_idx_r;
      b_val_r  <= a_val_r;
    end
  end

  // clip = P * eye, rows x, y and z
  for (genvar r = 0; r < 3; r++) begin : g_pj
    sum_t acc;
    for (genvar c = 0; c < 4; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (adv) c_prod_r[r][c] <= PROD_W'(pj_r[c*4+r]) * PROD_W'(b_eye_r[c]);
      end
    end
    assign acc = SUM_W'(c_prod_r[r][0] >>> FRAC_BITS) + SUM_W'(c_prod_r[r][1] >>> FRAC_BITS)
               + SUM_W'(c_prod_r[r][2] >>> FRAC_BITS) + SUM_W'(c_prod_r[r][3] >>> FRAC_BITS);
    always_ff @(posedge clk) begin
      if (adv) d_clip_r[r] <= sat_sum(acc);
    end
    ptsp_divider u_div (
      .clk     (clk),
      .en      (adv),
      .num     (d_clip_r[r]),
      .den_mag (d_den_mag_r),
      .den_neg (d_den_neg_r),
      .quo     (ndc[r])
    );
    assign ndc1[r] = (QW+1)'(ndc[r]) + ONE_X;
  end

  // divisor is minus eye z
  assign eye_z = b_eye_r[2];

  always_ff @(posedge clk) begin
    if (adv) begin
      c_zero_r    <= (eye_z == '0);
      c_den_mag_r <= eye_z[QW-1] ? QW'(-eye_z) : QW'(eye_z);
      c_den_neg_r <= !eye_z[QW-1] && (eye_z != '0);
      d_zero_r    <= c_zero_r;
      d_den_mag_r <= c_den_mag_r;
      d_den_neg_r <= c_den_neg_r;
      sv_zero_r   <= {sv_zero_r[DIV_LAT-2:0], d_zero_r};
    end
  end

  assign w_mul = VMUL_W'({1'b0, cfg.width});
  assign h_mul = VMUL_W'({1'b0, cfg.height});
  assign x_off = {{(SUM_W-OFS_W-FRAC_BITS){1'b0}}, cfg.x, {FRAC_BITS{1'b0}}};
  assign y_off = {{(SUM_W-OFS_W-FRAC_BITS){1'b0}}, cfg.y, {FRAC_BITS{1'b0}}};
  assign h_off = {{(SUM_W-DIM_W-FRAC_BITS){1'b0}}, cfg.height, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      f_x_r    <= VMUL_W'(ndc1[0]) * w_mul;
      f_y_r    <= VMUL_W'(ndc1[1]) * h_mul;
      f_z_r    <= ndc1[2];
      f_zero_r <= sv_zero_r[DIV_LAT-1];
      g_sx_r   <= sat_sum(SUM_W'(f_x_r >>> 1) + x_off);
      g_sy_r   <= sat_sum(SUM_W'(f_y_r >>> 1) + y_off);
      g_sd_r   <= sat_sum(SUM_W'(f_z_r >>> 1));
      g_zero_r <= f_zero_r;
      // y flipped against the viewport height
      out_x_r  <= g_zero_r ? '0 : g_sx_r;
      out_y_r  <= g_zero_r ? '0 : sat_sum(h_off - SUM_W'(g_sy_r));
      out_d_r  <= g_zero_r ? '0 : g_sd_r;
      out_ok_r <= !g_zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      sv_valid_r  <= '0;
      f_valid_r   <= 1'b0;
      g_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= pop;
      b_valid_r   <= a_valid_r;
      // loads end here, only points go on
      c_valid_r   <= b_valid_r && b_kind_r == KIND_PROJECT;
      d_valid_r   <= c_valid_r;
      sv_valid_r  <= {sv_valid_r[DIV_LAT-2:0], d_valid_r};
      f_valid_r   <= sv_valid_r[DIV_LAT-1];
      g_valid_r   <= f_valid_r;
      out_valid_r <= g_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_d_r, out_y_r, out_x_r};
  assign out_tuser  = out_ok_r;

endmodule

>>> src/point_to_screen_projection_core.sv
// top level of the point-to-screen projection core
// depends on ptsp_pkg, ptsp_front, ptsp_queue, ptsp_back and the macro header
`include "point_to_screen_projection_core_macros.svh"

// Projects object points to window coordinates in Q16.16. Load beats (tuser 0)
// write one coefficient of the modelview (index 0-15) or projection (16-31)
// matrix, column major, and give no result; project beats (tuser 1) give one
// result beat each. A beat is taken every cycle while the command queue has
// room, and one result leaves every cycle the output side accepts. From its
// input beat to its result a point passes the front register, the queue, the
// two matrix products, the perspective divider (one quotient bit per stage)
// and the viewport map and result register. The viewport registers may be
// written only while idle.
module point_to_screen_projection_core import ptsp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // coef_index[4:0], coef_value[36:5], pos_x[68:37], pos_y[100:69], pos_z[132:101]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // screen_x[31:0], screen_y[63:32], screen_depth[95:64]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // projected_ok
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  vp_cfg_t   cfg_r;
  logic      q_push, q_pop;
  cmd_t      q_in, q_head;
  q_status_t q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= VP_WIDTH_RST;
      cfg_r.height <= VP_HEIGHT_RST;
      cfg_r.x      <= VP_X_RST;
      cfg_r.y      <= VP_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VP_WIDTH:  cfg_r.width  <= cfg_data;
        REG_VP_HEIGHT: cfg_r.height <= cfg_data;
        REG_VP_X:      cfg_r.x      <= cfg_data[OFS_W-1:0];
        REG_VP_Y:      cfg_r.y      <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  ptsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (q_push),
    .push_cmd  (q_in),
    .q_status  (q_status)
  );

  ptsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  ptsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_status   (q_status),
    .pop        (q_pop),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `PTSP_ASSERT(a_no_push_full, !(q_push && q_status.full), "queue written while full")
  `PTSP_ASSERT(a_no_pop_empty, !(q_pop && q_status.empty), "queue read while empty")
  `PTSP_ASSERT_NEXT(a_fill, q_push && !q_pop, !q_status.empty, "queue lost a pushed beat")
  `PTSP_ASSERT(a_zero_result, !(out_tvalid && !out_tuser) || (out_tdata == '0), "eye z zero result not cleared")

endmodule
